>>> design/vlnf_pkg.sv
package vlnf_pkg;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_G     = 8'h47;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_PIPE  = 8'h7C;

    // Field numbers by count of preceding tabs.
    localparam logic [3:0] FIELD_FORMAT = 4'd8;
    localparam logic [3:0] FIELD_SAMPLE = 4'd9;
    localparam logic [3:0] TAB_SAT      = 4'd10;

    // Progress through the "#CHROM" header marker.
    localparam logic [2:0] CHROM_IDLE  = 3'd0;
    localparam logic [2:0] CHROM_FIRST = 3'd1;
    localparam logic [2:0] CHROM_LAST  = 3'd5;
    localparam logic [2:0] CHROM_FULL  = 3'd6;
    localparam logic [2:0] CHROM_MISS  = 3'd7;

    typedef enum logic [1:0] {
        KEY_START = 2'd0,
        KEY_G     = 2'd1,
        KEY_GT    = 2'd2,
        KEY_OTHER = 2'd3
    } t_key_step;

    typedef enum logic [2:0] {
        KIND_EMPTY    = 3'd0,
        KIND_HEADER   = 3'd1,
        KIND_PRE_HDR  = 3'd2,
        KIND_FEW      = 3'd3,
        KIND_NO_GT    = 3'd4,
        KIND_CHECKED  = 3'd5
    } t_line_kind;

    typedef struct packed {
        logic       valid;
        logic       keep;
        t_line_kind kind;
    } t_result;

    // Letter expected after '#' at each marker step.
    function automatic logic [7:0] chrom_char(input logic [2:0] step);
        logic [7:0] ch;
        case (step)
            3'd1:    ch = 8'h43;
            3'd2:    ch = 8'h48;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h4F;
            3'd5:    ch = 8'h4D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> design/vlnf_parse.sv
module vlnf_parse #(
    parameter int MAX_SUBFIELDS = 255
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_data,
    output vlnf_pkg::t_result   o_result
);

    localparam int CW = $clog2(MAX_SUBFIELDS + 1);
    localparam logic [CW-1:0] COLON_MAX = CW'(MAX_SUBFIELDS);

    typedef struct packed {
        logic                started;
        logic                hdr;
        logic [2:0]          chrom;
        logic                pcr;
        logic [3:0]          tabs;
        logic [CW-1:0]       colons;
        vlnf_pkg::t_key_step kms;
        logic [CW-1:0]       gt_pos;
        logic                gt_found;
        logic                smp_nonempty;
        logic                gt_nonempty;
        logic                gt_all_ref;
        logic                nonref;
    } t_line;

    function automatic t_line line_clear();
        t_line s;
        s              = '0;
        s.chrom        = vlnf_pkg::CHROM_IDLE;
        s.kms          = vlnf_pkg::KEY_START;
        s.gt_all_ref   = 1'b1;
        return s;
    endfunction

    function automatic t_line finish_key(input t_line si);
        t_line s;
        s = si;
        if (!s.gt_found && s.kms == vlnf_pkg::KEY_GT && s.colons < COLON_MAX) begin
            s.gt_found = 1'b1;
            s.gt_pos   = s.colons;
        end
        return s;
    endfunction

    function automatic t_line finish_sample(input t_line si);
        t_line s;
        s = si;
        if (!(s.smp_nonempty && s.gt_nonempty && s.gt_all_ref)) begin
            s.nonref = 1'b1;
        end
        return s;
    endfunction

    function automatic t_line feed(input t_line si, input logic [7:0] c);
        t_line s;
        logic  done;
        s    = si;
        done = 1'b0;
        if (!s.started) begin
            s.started = 1'b1;
            if (c == vlnf_pkg::CHAR_HASH) begin
                s.hdr   = 1'b1;
                s.chrom = vlnf_pkg::CHROM_FIRST;
                done    = 1'b1;
            end
        end else if (s.hdr) begin
            if (s.chrom >= vlnf_pkg::CHROM_FIRST && s.chrom <= vlnf_pkg::CHROM_LAST) begin
                if (c == vlnf_pkg::chrom_char(s.chrom)) begin
                    s.chrom = s.chrom + 3'd1;
                end else begin
                    s.chrom = vlnf_pkg::CHROM_MISS;
                end
            end
            done = 1'b1;
        end
        if (!done) begin
            if (c == vlnf_pkg::CHAR_TAB) begin
                if (s.tabs == vlnf_pkg::FIELD_FORMAT) begin
                    s = finish_key(s);
                end else if (s.tabs >= vlnf_pkg::FIELD_SAMPLE) begin
                    s = finish_sample(s);
                end
                if (s.tabs < vlnf_pkg::TAB_SAT) begin
                    s.tabs = s.tabs + 4'd1;
                end
                if (s.tabs == vlnf_pkg::FIELD_FORMAT) begin
                    s.colons = '0;
                    s.kms    = vlnf_pkg::KEY_START;
                end else if (s.tabs >= vlnf_pkg::FIELD_SAMPLE) begin
                    s.colons       = '0;
                    s.smp_nonempty = 1'b0;
                    s.gt_nonempty  = 1'b0;
                    s.gt_all_ref   = 1'b1;
                end
            end else if (s.tabs == vlnf_pkg::FIELD_FORMAT) begin
                if (c == vlnf_pkg::CHAR_COLON) begin
                    s = finish_key(s);
                    if (s.colons < COLON_MAX) begin
                        s.colons = s.colons + CW'(1);
                    end
                    s.kms = vlnf_pkg::KEY_START;
                end else if (s.kms == vlnf_pkg::KEY_START) begin
                    s.kms = (c == vlnf_pkg::CHAR_G) ? vlnf_pkg::KEY_G : vlnf_pkg::KEY_OTHER;
                end else if (s.kms == vlnf_pkg::KEY_G) begin
                    s.kms = (c == vlnf_pkg::CHAR_T) ? vlnf_pkg::KEY_GT : vlnf_pkg::KEY_OTHER;
                end else begin
                    s.kms = vlnf_pkg::KEY_OTHER;
                end
            end else if (s.tabs >= vlnf_pkg::FIELD_SAMPLE) begin
                s.smp_nonempty = 1'b1;
                if (c == vlnf_pkg::CHAR_COLON) begin
                    if (s.colons < COLON_MAX) begin
                        s.colons = s.colons + CW'(1);
                    end
                end else if (s.colons == s.gt_pos) begin
                    s.gt_nonempty = 1'b1;
                    if (c != vlnf_pkg::CHAR_ZERO && c != vlnf_pkg::CHAR_SLASH
                            && c != vlnf_pkg::CHAR_PIPE) begin
                        s.gt_all_ref = 1'b0;
                    end
                end
            end
        end
        return s;
    endfunction

    t_line             r_line;
    t_line             n_line;
    logic              r_header_seen;
    logic              n_header_seen;
    vlnf_pkg::t_result w_result;

    t_line             w_fed;
    t_line             w_fin;
    logic              w_close;

    always_comb begin
        w_fed = r_line;
        if (i_data_byte != vlnf_pkg::CHAR_LF) begin
            // A held CR turns out not to be trailing, so it is fed as data.
            if (w_fed.pcr) begin
                w_fed.pcr = 1'b0;
                w_fed     = feed(w_fed, vlnf_pkg::CHAR_CR);
            end
            if (i_data_byte == vlnf_pkg::CHAR_CR) begin
                w_fed.pcr = 1'b1;
            end else begin
                w_fed = feed(w_fed, i_data_byte);
            end
        end
        w_close = (i_data_byte == vlnf_pkg::CHAR_LF) || i_end_of_data;
        w_fin   = finish_sample(w_fed);

        n_header_seen   = r_header_seen;
        w_result.valid  = w_close;
        w_result.keep   = 1'b1;
        if (!w_fed.started) begin
            w_result.kind = vlnf_pkg::KIND_EMPTY;
        end else if (w_fed.hdr) begin
            w_result.kind = vlnf_pkg::KIND_HEADER;
            if (w_close && w_fed.chrom == vlnf_pkg::CHROM_FULL) begin
                n_header_seen = 1'b1;
            end
        end else if (!r_header_seen) begin
            w_result.kind = vlnf_pkg::KIND_PRE_HDR;
        end else if (w_fed.tabs < vlnf_pkg::FIELD_SAMPLE) begin
            w_result.kind = vlnf_pkg::KIND_FEW;
        end else if (!w_fed.gt_found) begin
            w_result.kind = vlnf_pkg::KIND_NO_GT;
        end else begin
            w_result.kind = vlnf_pkg::KIND_CHECKED;
            w_result.keep = w_fin.nonref;
        end

        if (w_close) begin
            n_line = line_clear();
        end else begin
            n_line = w_fed;
        end
        if (i_end_of_data) begin
            n_header_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line        <= line_clear();
            r_header_seen <= 1'b0;
        end else if (i_step) begin
            r_line        <= n_line;
            r_header_seen <= n_header_seen;
        end
    end

    assign o_result = w_result;

endmodule

>>> design/variant_line_nonref_filter_core.sv
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   i_data_byte, i_end_of_data
// result    out        o_valid / i_ready   o_keep_line, o_line_kind
//
// One byte is taken per cycle while o_ready is high; the line state is updated in
// the same cycle, so throughput is one byte per clock while o_ready is high. A line
// end or end of data registers its result in the output register or the skid one.
// A skid register behind the output holds one result while the consumer
// stalls; o_ready drops only while that skid register is occupied.
// Reset is synchronous, active low, and clears all line state and the header flag.
module variant_line_nonref_filter_core #(
    parameter int MAX_SUBFIELDS = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_keep_line,
    output logic [2:0] o_line_kind
);

    vlnf_pkg::t_result w_result;
    logic              w_step;

    logic              r_out_valid;
    logic              r_out_keep;
    logic [2:0]        r_out_kind;
    logic              r_skid_valid;
    logic              r_skid_keep;
    logic [2:0]        r_skid_kind;

    assign o_ready = !r_skid_valid;
    assign w_step  = i_valid && o_ready;

    vlnf_parse #(
        .MAX_SUBFIELDS(MAX_SUBFIELDS)
    ) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_data_byte   (i_data_byte),
        .i_end_of_data (i_end_of_data),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            // Output slot frees up: refill from skid first, else from the parser.
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_step && w_result.valid;
            end
        end else if (w_step && w_result.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_keep <= r_skid_keep;
                r_out_kind <= r_skid_kind;
            end else begin
                r_out_keep <= w_result.keep;
                r_out_kind <= w_result.kind;
            end
        end else if (w_step && w_result.valid) begin
            r_skid_keep <= w_result.keep;
            r_skid_kind <= w_result.kind;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_keep_line = r_out_keep;
    assign o_line_kind = r_out_kind;

endmodule

>>> verif/tb_variant_line_nonref_filter_core.sv
`timescale 1ns / 1ps

module tb_variant_line_nonref_filter_core;
    import vlnf_pkg::*;

    localparam int MAX_SUB        = 255;
    localparam int LIMIT_CYCLES   = 250000;
    localparam int RX_HOLD_CYCLES = 250;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RAND_BYTES     = 400;
    localparam int MIN_RAND_LINES = 30;
    localparam logic [7:0] HDR_MARK [0:5] = '{CHAR_HASH, "C", "H", "R", "O", "M"};

    typedef struct packed {
        logic       keep;
        t_line_kind kind;
    } line_verdict_t;

    typedef struct {
        string         text;
        bit            eod;
        bit            typed;
        line_verdict_t want;
    } stim_row_t;

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic [7:0] byte_data = 8'h00;
    logic       byte_eod = 1'b0;
    logic       verdict_ready = 1'b0;
    logic       byte_ready;
    logic       verdict_valid;
    logic       verdict_keep;
    logic [2:0] verdict_kind;

    // Line decisions still owed by the block, oldest first.
    line_verdict_t verdict_q [$];
    stim_row_t     dir_rows [$];
    logic [7:0]    line_buf [$];
    string         token_chars = "ACGT0123456789.;=_";

    int  errors = 0;
    int  checked = 0;
    int  dropped = 0;
    int  kind_hits [0:5] = '{default: 0};
    int  bytes_sent = 0;
    int  decisions_due = 0;
    int  cycle_cnt = 0;
    int  hold_ask = 0;
    int  hold_done = 0;
    bit  no_idle = 1'b0;
    line_verdict_t mon_want;

    // Predictor state for the line being parsed.
    logic       seen_chrom_hdr;
    logic       line_open;
    logic       line_is_hash;
    logic [2:0] chrom_step;
    logic       cr_held;
    logic [3:0] field_tabs;
    logic [7:0] sub_idx;
    t_key_step  key_step;
    logic [7:0] gt_idx;
    logic       gt_known;
    logic       smp_any;
    logic       gt_any;
    logic       gt_ref_only;
    logic       alt_hit;

    variant_line_nonref_filter_core #(
        .MAX_SUBFIELDS(MAX_SUB)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_valid      (byte_valid),
        .o_ready      (byte_ready),
        .i_data_byte  (byte_data),
        .i_end_of_data(byte_eod),
        .o_valid      (verdict_valid),
        .i_ready      (verdict_ready),
        .o_keep_line  (verdict_keep),
        .o_line_kind  (verdict_kind)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_line_state();
        line_open   = 1'b0;
        line_is_hash = 1'b0;
        chrom_step  = CHROM_IDLE;
        cr_held     = 1'b0;
        field_tabs  = '0;
        sub_idx     = '0;
        key_step    = KEY_START;
        gt_idx      = '0;
        gt_known    = 1'b0;
        smp_any     = 1'b0;
        gt_any      = 1'b0;
        gt_ref_only = 1'b1;
        alt_hit     = 1'b0;
    endfunction

    function automatic void bump_sub();
        if (sub_idx < MAX_SUB) begin
            sub_idx = sub_idx + 8'd1;
        end
    endfunction

    // Only the first GT key below the subfield limit sets the genotype position.
    function automatic void close_key();
        if (!gt_known && key_step == KEY_GT && sub_idx < MAX_SUB) begin
            gt_known = 1'b1;
            gt_idx   = sub_idx;
        end
    endfunction

    function automatic void close_sample();
        if (!(smp_any && gt_any && gt_ref_only)) begin
            alt_hit = 1'b1;
        end
    endfunction

    function automatic void absorb_char(input logic [7:0] c);
        if (!line_open) begin
            line_open = 1'b1;
            if (c == CHAR_HASH) begin
                line_is_hash = 1'b1;
                chrom_step   = CHROM_FIRST;
                return;
            end
        end else if (line_is_hash) begin
            if (chrom_step >= CHROM_FIRST && chrom_step <= CHROM_LAST) begin
                chrom_step = (c == HDR_MARK[chrom_step]) ? chrom_step + 3'd1 : CHROM_MISS;
            end
            return;
        end

        if (c == CHAR_TAB) begin
            if (field_tabs == FIELD_FORMAT) begin
                close_key();
            end else if (field_tabs >= FIELD_SAMPLE) begin
                close_sample();
            end
            if (field_tabs < TAB_SAT) begin
                field_tabs = field_tabs + 4'd1;
            end
            if (field_tabs == FIELD_FORMAT) begin
                sub_idx  = '0;
                key_step = KEY_START;
            end else if (field_tabs >= FIELD_SAMPLE) begin
                sub_idx     = '0;
                smp_any     = 1'b0;
                gt_any      = 1'b0;
                gt_ref_only = 1'b1;
            end
            return;
        end

        if (field_tabs == FIELD_FORMAT) begin
            if (c == CHAR_COLON) begin
                close_key();
                bump_sub();
                key_step = KEY_START;
            end else begin
                case (key_step)
                    KEY_START: key_step = (c == CHAR_G) ? KEY_G : KEY_OTHER;
                    KEY_G:     key_step = (c == CHAR_T) ? KEY_GT : KEY_OTHER;
                    default:   key_step = KEY_OTHER;
                endcase
            end
        end else if (field_tabs >= FIELD_SAMPLE) begin
            smp_any = 1'b1;
            if (c == CHAR_COLON) begin
                bump_sub();
            end else if (sub_idx == gt_idx) begin
                gt_any = 1'b1;
                if (c != CHAR_ZERO && c != CHAR_SLASH && c != CHAR_PIPE) begin
                    gt_ref_only = 1'b0;
                end
            end
        end
    endfunction

    function automatic void end_line_verdict(output line_verdict_t v);
        v.keep = 1'b1;
        if (!line_open) begin
            v.kind = KIND_EMPTY;
        end else if (line_is_hash) begin
            v.kind = KIND_HEADER;
            if (chrom_step == CHROM_FULL) begin
                seen_chrom_hdr = 1'b1;
            end
        end else if (!seen_chrom_hdr) begin
            v.kind = KIND_PRE_HDR;
        end else if (field_tabs < FIELD_SAMPLE) begin
            v.kind = KIND_FEW;
        end else begin
            close_sample();
            if (!gt_known) begin
                v.kind = KIND_NO_GT;
            end else begin
                v.kind = KIND_CHECKED;
                v.keep = alt_hit;
            end
        end
        clear_line_state();
    endfunction

    // Returns 1 when this byte closes a line and fills in the decision.
    function automatic bit predict_byte(input logic [7:0] b, input logic e,
                                        output line_verdict_t v);
        bit got;
        got = 1'b0;
        if (b == CHAR_LF) begin
            end_line_verdict(v);
            if (e) begin
                seen_chrom_hdr = 1'b0;
            end
            return 1'b1;
        end
        // A held CR turns out to be an ordinary byte.
        if (cr_held) begin
            cr_held = 1'b0;
            absorb_char(CHAR_CR);
        end
        if (b == CHAR_CR) begin
            cr_held = 1'b1;
        end else begin
            absorb_char(b);
        end
        if (e) begin
            end_line_verdict(v);
            seen_chrom_hdr = 1'b0;
            got = 1'b1;
        end
        return got;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic e, input bit use_typed,
                             input line_verdict_t typed_val);
        line_verdict_t got;
        if (!no_idle && $urandom_range(0, 11) == 0) begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= b;
        byte_eod   <= e;
        if (predict_byte(b, e, got)) begin
            verdict_q.insert(verdict_q.size(), use_typed ? typed_val : got);
            decisions_due++;
        end
        bytes_sent++;
        @(posedge i_clk);
        while (!byte_ready) @(posedge i_clk);
    endtask

    function automatic void add_row(input string text, input bit eod, input bit typed,
                                    input logic keep, input t_line_kind kind);
        stim_row_t row;
        row.text      = text;
        row.eod       = eod;
        row.typed     = typed;
        row.want.keep = keep;
        row.want.kind = kind;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i]);
        end
    endfunction

    function automatic void put_token(input int max_len);
        int n;
        n = $urandom_range(0, max_len);
        for (int i = 0; i < n; i++) begin
            put_byte(token_chars[$urandom_range(0, token_chars.len() - 1)]);
        end
    endfunction

    function automatic void put_genotype();
        int r;
        r = $urandom_range(0, 19);
        if (r < 11) begin
            case ($urandom_range(0, 6))
                0: put_text("0/0");
                1: put_text("0|0");
                2: put_text("0");
                3: put_text("0/0/0");
                4: put_text("/");
                5: put_text("|");
                default: put_text("00");
            endcase
        end else if (r < 16) begin
            case ($urandom_range(0, 5))
                0: put_text("0/1");
                1: put_text("1|1");
                2: put_text("./.");
                3: put_text("1");
                4: put_text("0/.");
                default: put_text("2");
            endcase
        end else if (r == 17) begin
            put_text("0\0150");
        end else if (r > 17) begin
            put_token(3);
        end
        // r == 16 leaves the genotype empty.
    endfunction

    function automatic void put_filler_key();
        case ($urandom_range(0, 8))
            0: put_text("DP");
            1: put_text("GQ");
            2: put_text("G");
            3: put_text("GTT");
            4: put_text("AD");
            5: put_text("T");
            6: put_text("TG");
            7: put_text("XGT");
            default: ;
        endcase
    endfunction

    // Mostly well-formed data lines after a column header, with broken
    // lines, headers and raw noise mixed in.
    task automatic emit_random_line();
        int  cat;
        int  nk;
        int  gpos;
        int  ns;
        int  nsub;
        int  t;
        bit  eod_last;
        cat = $urandom_range(0, 99);
        eod_last = 1'b0;
        line_buf.delete();
        if (!seen_chrom_hdr && $urandom_range(0, 9) < 7) begin
            put_text("#CHROM");
            if ($urandom_range(0, 1) == 1) begin
                put_text("\tPOS");
                put_token(4);
            end
        end else if (cat < 63) begin
            for (int f = 0; f < 8; f++) begin
                put_token(4);
                put_byte(CHAR_TAB);
            end
            nk = $urandom_range(1, 4);
            gpos = (cat < 55 && $urandom_range(0, 19) != 0) ? $urandom_range(0, nk - 1) : nk;
            for (int k = 0; k < nk; k++) begin
                if (k > 0) put_byte(CHAR_COLON);
                if (k == gpos) put_text("GT");
                else put_filler_key();
            end
            if (gpos < nk - 1 && $urandom_range(0, 9) == 0) begin
                put_text(":GT");
            end
            ns = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            for (int s = 0; s < ns; s++) begin
                put_byte(CHAR_TAB);
                if ($urandom_range(0, 19) != 0) begin
                    nsub = ($urandom_range(0, 9) == 0) ? $urandom_range(1, nk) : nk;
                    for (int k = 0; k < nsub; k++) begin
                        if (k > 0) put_byte(CHAR_COLON);
                        if (k == gpos) put_genotype();
                        else put_token(2);
                    end
                end
            end
        end else if (cat < 71) begin
            for (int f = 0; f < $urandom_range(1, 9); f++) begin
                if (f > 0) put_byte(CHAR_TAB);
                put_token(3);
            end
        end else if (cat < 79) begin
            case ($urandom_range(0, 4))
                0: put_text("##");
                1: put_text("#CHROMX");
                2: put_text("#CHRO");
                3: put_text("#");
                default: put_text("#CHRXM\t1");
            endcase
            put_token(5);
        end else if (cat < 87) begin
            if ($urandom_range(0, 1) == 1) put_byte(CHAR_CR);
        end else begin
            for (int i = 0; i < $urandom_range(1, 20); i++) begin
                put_byte(8'($urandom_range(0, 255)));
            end
        end

        t = $urandom_range(0, 99);
        if (t < 84) begin
            put_byte(CHAR_LF);
        end else if (t < 92) begin
            put_byte(CHAR_CR);
            put_byte(CHAR_LF);
        end else if (t < 96) begin
            put_byte(CHAR_LF);
            eod_last = 1'b1;
        end else begin
            if (line_buf.size() == 0) put_byte(CHAR_CR);
            eod_last = 1'b1;
        end
        for (int i = 0; i < line_buf.size(); i++) begin
            send_byte(line_buf[i], eod_last && i == line_buf.size() - 1, 1'b0, '0);
        end
    endtask

    task automatic emit_lines_until(input int target);
        while (bytes_sent < target) emit_random_line();
    endtask

    // Receiver: random ready pattern, plus long hold-offs on request.
    initial begin
        forever begin
            if (hold_done != hold_ask) begin
                verdict_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                verdict_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                verdict_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && verdict_valid && verdict_ready) begin
            if (verdict_q.size() == 0) begin
                errors++;
                if (errors < 40) begin
                    $display("%0t: decision with none expected: keep=%0d kind=%0d",
                             $time, verdict_keep, verdict_kind);
                end
            end else begin
                mon_want = verdict_q.pop_front();
                checked++;
                if (!verdict_keep) dropped++;
                if (verdict_kind <= KIND_CHECKED) kind_hits[int'(verdict_kind)]++;
                if (verdict_keep !== mon_want.keep) begin
                    errors++;
                    if (errors < 40) begin
                        $display("%0t: keep_line mismatch: expected %0d, got %0d",
                                 $time, mon_want.keep, verdict_keep);
                    end
                end
                if (verdict_kind !== mon_want.kind) begin
                    errors++;
                    if (errors < 40) begin
                        $display("%0t: line_kind mismatch: expected %0d, got %0d",
                                 $time, mon_want.kind, verdict_kind);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d decisions pending.",
                     cycle_cnt, verdict_q.size());
            $display("FAIL variant_line_nonref_filter_core");
            $finish;
        end
    end

    initial begin
        string vp;
        string c254;
        string c255;
        string c260;
        int    rand_start;
        int    dec_at_rand;
        stim_row_t row;

        seen_chrom_hdr = 1'b0;
        clear_line_state();

        vp = "c\t1\t.\tA\tC\t.\t.\t.\t";
        c254 = "";
        for (int i = 0; i < 254; i++) c254 = {c254, ":"};
        c255 = {c254, ":"};
        c260 = {c255, ":::::"};

        // Directed lines; the obvious outcomes are written in, the rest predicted.
        add_row("\n", 0, 1, 1'b1, KIND_EMPTY);
        add_row("\015\n", 0, 1, 1'b1, KIND_EMPTY);
        add_row("\015", 1, 1, 1'b1, KIND_EMPTY);
        add_row("##meta\n", 0, 1, 1'b1, KIND_HEADER);
        add_row("#CHRO\tx\n", 0, 1, 1'b1, KIND_HEADER);
        add_row("1\t2\t3\t4\t5\t6\t7\t8\tGT\t0/0\n", 0, 1, 1'b1, KIND_PRE_HDR);
        add_row("#CHROM\tPOS\n", 0, 1, 1'b1, KIND_HEADER);
        add_row("#x\n", 0, 1, 1'b1, KIND_HEADER);
        add_row("a\tb\tc\td\te\tf\tg\th\tGT\n", 0, 1, 1'b1, KIND_FEW);
        add_row("\377\t\200\tQ\n", 0, 1, 1'b1, KIND_FEW);
        add_row({vp, "DP:GQ\t5:9\n"}, 0, 1, 1'b1, KIND_NO_GT);
        add_row({vp, "GT:DP\t0/0:3\t0|0:1\t0\n"}, 0, 0, 1'b0, KIND_EMPTY);
        add_row({vp, "GT\t0/1\t0/0\n"}, 0, 0, 1'b0, KIND_EMPTY);
        add_row({vp, "DP:GT\t3:0/0\t:0\n"}, 0, 0, 1'b0, KIND_EMPTY);
        add_row({vp, "GT\t0/0\t\n"}, 0, 0, 1'b0, KIND_EMPTY);
        add_row({vp, "DP:GT\t3\t4:0\n"}, 0, 0, 1'b0, KIND_EMPTY);
        add_row({vp, "GT\t0\0150\n"}, 0, 0, 1'b0, KIND_EMPTY);
        add_row({vp, "GT\t0/0\015\n"}, 0, 0, 1'b0, KIND_EMPTY);
        add_row({vp, "GT\t0\t0\t0\t0\t0\n"}, 0, 0, 1'b0, KIND_EMPTY);
        add_row({vp, "G:GTX:GT:GT\t1:1:0:1\n"}, 0, 0, 1'b0, KIND_EMPTY);
        add_row({vp, c255, "GT\t0\n"}, 0, 1, 1'b1, KIND_NO_GT);
        add_row({vp, c254, "GT\t", c254, "0\t", c260, "1\n"}, 0, 0, 1'b0, KIND_EMPTY);
        add_row({vp, "GT\t0/0"}, 1, 0, 1'b0, KIND_EMPTY);
        add_row("#CHROM\n", 1, 1, 1'b1, KIND_HEADER);
        add_row({vp, "GT\t0/0\n"}, 0, 1, 1'b1, KIND_PRE_HDR);

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            for (int i = 0; i < row.text.len(); i++) begin
                send_byte(row.text[i], row.eod && i == row.text.len() - 1, row.typed,
                          row.want);
            end
        end

        rand_start  = bytes_sent;
        dec_at_rand = decisions_due;
        emit_lines_until(rand_start + 100);

        // Stall the receiver and keep offering empty lines until input backs up.
        hold_ask++;
        repeat (24) send_byte(CHAR_LF, 1'b0, 1'b0, '0);

        emit_lines_until(rand_start + 200);

        // Let the block drain completely before going on.
        byte_valid <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);

        emit_lines_until(rand_start + 300);
        no_idle = 1'b1;
        emit_lines_until(rand_start + RAND_BYTES);
        while (decisions_due - dec_at_rand < MIN_RAND_LINES) emit_random_line();

        byte_valid <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Streamed %0d bytes; %0d line decisions checked, %0d of them drops.",
                 bytes_sent, checked, dropped);
        $display("Kinds: empty %0d, header %0d, pre-header %0d, short %0d, no GT %0d, %0s%0d.",
                 kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4],
                 "samples checked ", kind_hits[5]);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("PASS variant_line_nonref_filter_core");
        end else begin
            $display("FAIL variant_line_nonref_filter_core");
        end
        $finish;
    end

endmodule
